// ===== rtl/core/dq_pkg.sv =====
// Shared types and constants for the double-ended queue block.
// Holds the transfer structs, the action and status codes and the store sizes.
// No dependencies.
`default_nettype none

package dq_pkg;

    // Store geometry; the depth is a power of two so slot indexes wrap by themselves.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_FRONT = 3'd4,
        ACT_READ_BACK  = 3'd5,
        ACT_MIDDLE     = 3'd6,
        ACT_REVERSE    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic signed [DATA_W-1:0]  value;
    } dq_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        status_t                   status;
        logic [CNT_W-1:0]          occupancy;
        logic                      empty_flag;
    } dq_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/dq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the read enable.
// No dependencies.
`default_nettype none

module dq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue_with_reverse_unit.sv =====
// Top level of the bounded double-ended queue with an order-reversal flag.
// Depends on dq_pkg for types and constants and on dq_ram for the slot store.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------------
//   request  | req_valid/stall  | req : dq_req_t (action, value)
//   response | rsp_valid/stall  | rsp : dq_rsp_t (data, status, occupancy, empty_flag)
//
// One request is accepted per cycle while req_stall is low; its response passes
// through the read stage, which covers the store's registered read port, and the output register.
// Reset clears the head index, the count and the direction flag; the store
// itself is not cleared, since only live slots are ever read.
// A stalled response holds the output register; the stage behind it holds too,
// and requests are stalled only when both are occupied.
`default_nettype none

module double_ended_queue_with_reverse_unit
    import dq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire dq_req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output dq_rsp_t   rsp
);

    // Queue control state.
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;

    // Read stage: response fields waiting for the store's read data.
    logic              s1_valid_reg;
    dq_rsp_t           s1_rsp_reg, s1_rsp_next;
    logic              s1_rd_reg, s1_rd_next;

    // Output register.
    logic              rsp_valid_reg;
    dq_rsp_t           rsp_reg, rsp_next;

    // Store access.
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              s1_advance;
    logic              accept;
    logic              is_full;
    logic              is_zero;
    logic [CNT_W-1:0]  last_pos;
    logic [CNT_W-1:0]  mid_pos;
    logic [CNT_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] back_addr;

    // Pipeline flow: the read stage moves on when the output register frees up.
    assign s1_advance = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = s1_valid_reg && !s1_advance;
    assign accept     = req_valid && !req_stall;

    // Positions derived from the current count.
    assign is_full   = (count_reg >= CNT_W'(DEPTH));
    assign is_zero   = (count_reg == '0);
    assign last_pos  = count_reg - CNT_W'(1);
    assign mid_pos   = rev_reg ? (last_pos - (count_reg >> 1)) : (count_reg >> 1);
    assign back_addr = head_reg + last_pos[ADDR_W-1:0];

    // Action decode: next control state, store access and response fields.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        wr_en       = 1'b0;
        wr_addr     = head_reg + count_reg[ADDR_W-1:0];
        rd_en       = 1'b0;
        rd_pos      = '0;
        s1_rd_next  = 1'b0;
        s1_rsp_next.status = ST_OK;

        if (accept)
        begin
            unique case (req.action)
                ACT_PUSH_FRONT, ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        s1_rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        // A logical front push lands on the physical back when reversed.
                        if ((req.action == ACT_PUSH_FRONT) != rev_reg)
                        begin
                            head_next = head_reg - ADDR_W'(1);
                            wr_addr   = head_reg - ADDR_W'(1);
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK:
                begin
                    if (is_zero)
                    begin
                        s1_rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        s1_rd_next = 1'b1;
                        count_next = last_pos;
                        if ((req.action == ACT_POP_FRONT) != rev_reg)
                        begin
                            rd_pos    = '0;
                            head_next = head_reg + ADDR_W'(1);
                        end
                        else
                        begin
                            rd_pos = last_pos;
                        end
                    end
                end
                ACT_READ_FRONT, ACT_READ_BACK, ACT_MIDDLE:
                begin
                    if (is_zero)
                    begin
                        s1_rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        s1_rd_next = 1'b1;
                        if (req.action == ACT_MIDDLE)
                        begin
                            rd_pos = mid_pos;
                        end
                        else if ((req.action == ACT_READ_FRONT) != rev_reg)
                        begin
                            rd_pos = '0;
                        end
                        else
                        begin
                            rd_pos = last_pos;
                        end
                    end
                end
                ACT_REVERSE:
                begin
                    if (is_zero)
                    begin
                        s1_rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rev_next = !rev_reg;
                    end
                end
                default:
                begin
                    s1_rsp_next.status = ST_OK;
                end
            endcase
        end

        s1_rsp_next.data       = '0;
        s1_rsp_next.occupancy  = count_next;
        s1_rsp_next.empty_flag = (count_next == '0);
    end

    // Back-of-queue reads use the precomputed address to keep the adder short.
    assign rd_addr = (rd_pos == last_pos && !is_zero) ? back_addr
                                                      : head_reg + rd_pos[ADDR_W-1:0];

    // Slot store.
    dq_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Output payload: the read stage fields with the store data merged in.
    always_comb
    begin
        rsp_next      = s1_rsp_reg;
        rsp_next.data = s1_rd_reg ? rd_data : '0;
    end

    // Payload registers of the read stage and the output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rsp_reg <= s1_rsp_next;
            s1_rd_reg  <= s1_rd_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== test/double_ended_queue_with_reverse_unit_test.sv =====
// Self-checking testbench for the bounded double-ended queue with order reversal.
// Drives a directed table and random fill/drain traffic, and predicts every response.
// Depends on dq_pkg and double_ended_queue_with_reverse_unit.
`default_nettype none

module double_ended_queue_with_reverse_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int RANDOM_PER_PHASE = 475;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MODE_MIX         = 0;
    localparam int MODE_FILL        = 1;
    localparam int MODE_DRAIN       = 2;

    typedef struct {
        action_t                  action;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        dq_rsp_t                  typed_rsp;
    } stim_row_t;

    logic    clk;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    dq_req_t req       = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    dq_rsp_t rsp;

    int idle_pct       = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;

    // Shadow copy of the deque contents and pointers.
    logic signed [DATA_W-1:0] deque_slots [DEPTH];
    logic [ADDR_W-1:0]        deque_head     = '0;
    logic [CNT_W-1:0]         deque_count    = '0;
    bit                       deque_reversed = 1'b0;

    dq_rsp_t   expected_rsps [$];
    stim_row_t directed_rows [$];

    double_ended_queue_with_reverse_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", expected_rsps.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Applies one action to the shadow deque and returns the response it should give.
    function automatic dq_rsp_t predict_deque(input dq_req_t r);
        dq_rsp_t           result;
        logic [ADDR_W-1:0] slot;
        logic [CNT_W-1:0]  pos;
        bit                at_front;
        result        = '0;
        result.status = ST_OK;
        if (r.action == ACT_PUSH_FRONT || r.action == ACT_PUSH_BACK)
        begin
            if (deque_count >= DEPTH)
                result.status = ST_FULL;
            else
            begin
                // A logical front push lands on the physical back when reversed.
                at_front = (r.action == ACT_PUSH_FRONT) != deque_reversed;
                if (at_front)
                begin
                    deque_head = deque_head - 1'b1;
                    deque_slots[deque_head] = r.value;
                end
                else
                begin
                    slot = deque_head + deque_count[ADDR_W-1:0];
                    deque_slots[slot] = r.value;
                end
                deque_count++;
            end
        end
        else if (deque_count == 0)
            result.status = ST_EMPTY;
        else
        begin
            case (r.action)
                ACT_POP_FRONT, ACT_POP_BACK:
                begin
                    if ((r.action == ACT_POP_FRONT) != deque_reversed)
                    begin
                        result.data = deque_slots[deque_head];
                        deque_head  = deque_head + 1'b1;
                    end
                    else
                    begin
                        slot        = deque_head + deque_count[ADDR_W-1:0] - 1'b1;
                        result.data = deque_slots[slot];
                    end
                    deque_count--;
                end
                ACT_REVERSE:
                    deque_reversed = !deque_reversed;
                default:
                begin
                    // Logical position first, then mapped to a physical one.
                    if (r.action == ACT_READ_FRONT)
                        pos = '0;
                    else if (r.action == ACT_READ_BACK)
                        pos = deque_count - 1'b1;
                    else
                        pos = deque_count >> 1;
                    if (deque_reversed)
                        pos = deque_count - 1'b1 - pos;
                    slot        = deque_head + pos[ADDR_W-1:0];
                    result.data = deque_slots[slot];
                end
            endcase
        end
        result.occupancy  = deque_count;
        result.empty_flag = (deque_count == 0);
        return result;
    endfunction

    function automatic stim_row_t row(input action_t a, input logic signed [DATA_W-1:0] v,
                                      input bit t = 1'b0,
                                      input logic signed [DATA_W-1:0] d = '0,
                                      input status_t s = ST_OK, input int occ = 0);
        stim_row_t entry;
        entry.action               = a;
        entry.value                = v;
        entry.typed                = t;
        entry.typed_rsp.data       = d;
        entry.typed_rsp.status     = s;
        entry.typed_rsp.occupancy  = CNT_W'(occ);
        entry.typed_rsp.empty_flag = (occ == 0);
        return entry;
    endfunction

    // Presents one request, waits for its transfer and records the expected response.
    task automatic send_request(input dq_req_t r, input bit typed, input dq_rsp_t typed_rsp);
        dq_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predicted = predict_deque(r);
        expected_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    // Response side stalls at the rate of the current phase.
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Every response transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        dq_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch($sformatf("response with none pending, data %0d", rsp.data));
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.data !== want.data)
                    report_mismatch($sformatf("data %0d, wanted %0d", rsp.data, want.data));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp.status, want.status));
                if (rsp.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, wanted %0d",
                                              rsp.occupancy, want.occupancy));
                if (rsp.empty_flag !== want.empty_flag)
                    report_mismatch($sformatf("empty_flag %0b, wanted %0b",
                                              rsp.empty_flag, want.empty_flag));
            end
        end
    end

    initial
    begin
        dq_req_t r;
        int      mode;
        int      pick;
        int      phase_idle  [4];
        int      phase_stall [4];

        phase_idle  = '{0, 68, 0, 12};
        phase_stall = '{0, 0, 68, 12};

        // Empty-deque errors first, then extremes pushed at both ends, then reversal, reads and pops to empty.
        directed_rows = '{
            row(ACT_POP_FRONT,  32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0),
            row(ACT_POP_BACK,   32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0),
            row(ACT_READ_FRONT, 32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0),
            row(ACT_READ_BACK,  32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0),
            row(ACT_MIDDLE,     32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0),
            row(ACT_REVERSE,    32'sd0, 1'b1, 32'sd0, ST_EMPTY, 0),
            row(ACT_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1, 32'sd0, ST_OK, 1),
            row(ACT_PUSH_BACK,  32'sh8000_0000, 1'b1, 32'sd0, ST_OK, 2),
            row(ACT_PUSH_FRONT, -32'sd1,        1'b1, 32'sd0, ST_OK, 3),
            row(ACT_PUSH_BACK,  32'sh0000_0000, 1'b1, 32'sd0, ST_OK, 4),
            row(ACT_READ_FRONT, 32'sh1234_5678),
            row(ACT_READ_BACK,  32'sd0),
            row(ACT_MIDDLE,     32'sd0),
            row(ACT_REVERSE,    32'sd0, 1'b1, 32'sd0, ST_OK, 4),
            row(ACT_READ_FRONT, 32'sd0),
            row(ACT_MIDDLE,     32'sd0),
            row(ACT_PUSH_FRONT, 32'sh5555_5555),
            row(ACT_MIDDLE,     32'sd0),
            row(ACT_POP_FRONT,  32'sd0),
            row(ACT_POP_BACK,   32'sd0),
            row(ACT_REVERSE,    32'sd0),
            row(ACT_POP_FRONT,  32'sd0),
            row(ACT_POP_BACK,   32'sd0),
            row(ACT_POP_FRONT,  32'sd0),
            row(ACT_READ_BACK,  32'shAAAA_AAAA, 1'b1, 32'sd0, ST_EMPTY, 0)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            r.action = directed_rows[i].action;
            r.value  = directed_rows[i].value;
            send_request(r, directed_rows[i].typed, directed_rows[i].typed_rsp);
        end

        // Random traffic: fill bursts run into the full limit, drain bursts back to empty.
        mode = MODE_FILL;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = phase_idle[phase];
            stall_pct = phase_stall[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                case (mode)
                    MODE_FILL:
                        if (deque_count == DEPTH && pick < 20)
                            mode = MODE_DRAIN;
                    MODE_DRAIN:
                        if (deque_count == 0 && pick < 20)
                            mode = MODE_MIX;
                    default:
                        if (pick < 1)
                            mode = $urandom_range(1) ? MODE_FILL : MODE_DRAIN;
                endcase
                pick = $urandom_range(99);
                if (mode == MODE_FILL && pick < 85)
                    r.action = action_t'($urandom_range(ACT_PUSH_BACK, ACT_PUSH_FRONT));
                else if (mode == MODE_DRAIN && pick < 70)
                    r.action = action_t'($urandom_range(ACT_POP_BACK, ACT_POP_FRONT));
                else
                    r.action = action_t'($urandom_range(ACT_REVERSE, ACT_PUSH_FRONT));
                r.value = $urandom();
                send_request(r, 1'b0, '0);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
